// ===== rtl/riff_wave_header_parser_core_macros.svh =====
// Assertion macros for the parser RTL.
`ifndef RIFF_WAVE_HEADER_PARSER_CORE_MACROS_SVH
`define RIFF_WAVE_HEADER_PARSER_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define RWHP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define RWHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RWHP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RWHP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/rwhp_pkg.sv =====
package rwhp_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_AFTER   = 2'd3;

    // Format classes.
    localparam logic [1:0] CLASS_PCM   = 2'd0;
    localparam logic [1:0] CLASS_EXT   = 2'd1;
    localparam logic [1:0] CLASS_OTHER = 2'd2;

    // Four-character codes, first character in the top byte.
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] FMT_PCM = 16'h0001;
    localparam logic [15:0] FMT_EXT = 16'hFFFE;

    // Number of captured fmt body bytes.
    localparam int          FMT_LEN = 18;
    localparam int          OFF_W   = $clog2(FMT_LEN + 1);

    // Parser phase, one-hot.
    typedef enum logic [10:0] {
        PH_RIFF  = 11'b000_0000_0001,
        PH_RSIZE = 11'b000_0000_0010,
        PH_WAVE  = 11'b000_0000_0100,
        PH_ID    = 11'b000_0000_1000,
        PH_SIZE  = 11'b000_0001_0000,
        PH_FMT   = 11'b000_0010_0000,
        PH_SKIP  = 11'b000_0100_0000,
        PH_PAD   = 11'b000_1000_0000,
        PH_DATA  = 11'b001_0000_0000,
        PH_DONE  = 11'b010_0000_0000,
        PH_ERR   = 11'b100_0000_0000
    } t_phase;

    typedef logic [7:0] t_fmt_bytes [FMT_LEN];

    // One result beat.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        last_payload;
        logic [1:0]  format_class;
        logic [15:0] format_tag;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [15:0] extra_size;
        logic [31:0] data_size;
    } t_out_beat;

endpackage

// ===== rtl/rwhp_if.sv =====
// Input channel: one file byte per beat.
interface rwhp_in_if;
    logic       valid;
    logic       ready;
    logic       restart;
    logic [7:0] in_byte;

    modport source (output valid, output restart, output in_byte, input ready);
    modport sink (input valid, input restart, input in_byte, output ready);
endinterface

// Output channel: one result per beat.
interface rwhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        last_payload;
    logic [1:0]  format_class;
    logic [15:0] format_tag;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [15:0] extra_size;
    logic [31:0] data_size;

    modport source (
        output valid, input ready,
        output kind, output data_byte, output last_payload, output format_class,
        output format_tag, output channels, output sample_rate, output byte_rate,
        output block_align, output bits_per_sample, output extra_size, output data_size
    );
    modport sink (
        input valid, output ready,
        input kind, input data_byte, input last_payload, input format_class,
        input format_tag, input channels, input sample_rate, input byte_rate,
        input block_align, input bits_per_sample, input extra_size, input data_size
    );
endinterface

// ===== rtl/riff_wave_header_parser_core.sv =====
// RIFF/WAVE header parser. The block takes a WAV file image one byte per input beat and
// returns exactly one result beat per byte: header byte consumed, payload byte (with the
// last one marked), error, or byte after the payload. It checks the RIFF and WAVE magic,
// walks the chunks, skips unknown ones and pad bytes, captures the first 18 bytes of the
// fmt body and passes the data chunk payload through. Restart on a beat resets the
// parser before that byte is handled. It sustains one byte per clock while the output is not
// stalled: each byte passes an input register, one pass of next-state logic (its longest
// path is the 32-bit bytes-left decrement and zero test) and the result register. No
// clearing pass is needed after reset.
`include "riff_wave_header_parser_core_macros.svh"

module riff_wave_header_parser_core
    import rwhp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rwhp_in_if.sink     i_in,
    rwhp_out_if.source  o_out
);

    // Input register.
    logic        r_s1_valid;
    logic        r_s1_restart;
    logic [7:0]  r_s1_byte;

    // Parser state.
    t_phase            r_phase,  n_phase;
    logic [1:0]        r_bif,    n_bif;
    logic [31:0]       r_id,     n_id;
    logic [31:0]       r_size,   n_size;
    logic [31:0]       r_left,   n_left;
    logic              r_seen,   n_seen;
    logic [OFF_W-1:0]  r_off,    n_off;
    t_fmt_bytes        r_fmt,    n_fmt;

    // Result register.
    logic        r_out_valid;
    t_out_beat   r_out, n_out;

    // Current state, after an optional restart.
    t_phase            c_phase;
    logic [1:0]        c_bif;
    logic [31:0]       c_id;
    logic [31:0]       c_size;
    logic [31:0]       c_left;
    logic              c_seen;
    logic [OFF_W-1:0]  c_off;
    t_fmt_bytes        c_fmt;

    logic        s1_advance;
    logic        fourth;
    logic [31:0] id_shift;
    logic [31:0] left_dec;
    logic [15:0] tag;

    assign s1_advance = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_advance;

    // Input beat capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_s1_restart <= i_in.restart;
            r_s1_byte    <= i_in.in_byte;
        end
    end

    // A restart beat sees the reset state.
    always_comb begin
        if (r_s1_restart) begin
            c_phase = PH_RIFF;
            c_bif   = '0;
            c_id    = '0;
            c_size  = '0;
            c_left  = '0;
            c_seen  = 1'b0;
            c_off   = '0;
            for (int k = 0; k < FMT_LEN; k++) c_fmt[k] = '0;
        end else begin
            c_phase = r_phase;
            c_bif   = r_bif;
            c_id    = r_id;
            c_size  = r_size;
            c_left  = r_left;
            c_seen  = r_seen;
            c_off   = r_off;
            c_fmt   = r_fmt;
        end
    end

    assign fourth   = (c_bif == 2'd3);
    assign id_shift = {c_id[23:0], r_s1_byte};
    assign left_dec = c_left - 32'd1;

    // Next-state logic for one byte.
    always_comb begin
        n_phase = c_phase;
        n_bif   = c_bif;
        n_id    = c_id;
        n_size  = c_size;
        n_left  = c_left;
        n_seen  = c_seen;
        n_off   = c_off;
        n_fmt   = c_fmt;
        n_out   = '0;
        n_out.kind = KIND_HEADER;

        case (c_phase)
            PH_RIFF, PH_WAVE, PH_ID: begin
                n_id  = id_shift;
                n_bif = c_bif + 2'd1;
                if (fourth) begin
                    if (c_phase == PH_RIFF) begin
                        if (id_shift != TAG_RIFF) begin
                            n_phase    = PH_ERR;
                            n_out.kind = KIND_ERROR;
                        end else begin
                            n_phase = PH_RSIZE;
                        end
                    end else if (c_phase == PH_WAVE) begin
                        if (id_shift != TAG_WAVE) begin
                            n_phase    = PH_ERR;
                            n_out.kind = KIND_ERROR;
                        end else begin
                            n_phase = PH_ID;
                        end
                    end else if (id_shift == TAG_DATA && !c_seen) begin
                        n_phase    = PH_ERR;
                        n_out.kind = KIND_ERROR;
                    end else begin
                        if (id_shift == TAG_FMT) begin
                            n_seen = 1'b1;
                            for (int k = 0; k < FMT_LEN; k++) n_fmt[k] = '0;
                        end
                        n_size  = '0;
                        n_phase = PH_SIZE;
                    end
                end
            end
            PH_RSIZE: begin
                n_bif = c_bif + 2'd1;
                if (fourth) begin
                    n_id    = '0;
                    n_phase = PH_WAVE;
                end
            end
            PH_SIZE: begin
                n_size[{c_bif, 3'b000} +: 8] = c_size[{c_bif, 3'b000} +: 8] | r_s1_byte;
                n_bif = c_bif + 2'd1;
                if (fourth) begin
                    n_left = n_size;
                    n_off  = '0;
                    if (c_id == TAG_DATA) begin
                        if (n_size == 32'd0) begin
                            n_phase    = PH_ERR;
                            n_out.kind = KIND_ERROR;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end else if (n_size == 32'd0) begin
                        n_phase = PH_ID;
                    end else if (c_id == TAG_FMT) begin
                        n_phase = PH_FMT;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_FMT, PH_SKIP: begin
                // Capture the leading fmt body bytes; the rest are dropped.
                if (c_phase == PH_FMT && c_off < OFF_W'(FMT_LEN)) begin
                    n_fmt[c_off] = r_s1_byte;
                    n_off        = c_off + OFF_W'(1);
                end
                n_left = left_dec;
                if (left_dec == 32'd0) begin
                    n_phase = c_size[0] ? PH_PAD : PH_ID;
                end
            end
            PH_PAD: begin
                n_phase = PH_ID;
            end
            PH_DATA: begin
                n_out.kind      = KIND_PAYLOAD;
                n_out.data_byte = r_s1_byte;
                n_left          = left_dec;
                if (left_dec == 32'd0) begin
                    n_out.last_payload = 1'b1;
                    n_phase            = PH_DONE;
                end
            end
            PH_DONE: begin
                n_out.kind = KIND_AFTER;
            end
            PH_ERR: begin
                n_out.kind = KIND_ERROR;
            end
            default: begin
                n_phase    = PH_ERR;
                n_out.kind = KIND_ERROR;
            end
        endcase

        // Captured fields as seen after this byte.
        tag                   = {n_fmt[1], n_fmt[0]};
        n_out.format_tag      = tag;
        n_out.format_class    = (tag == FMT_PCM) ? CLASS_PCM :
                                (tag == FMT_EXT) ? CLASS_EXT : CLASS_OTHER;
        n_out.channels        = {n_fmt[3], n_fmt[2]};
        n_out.sample_rate     = {n_fmt[7], n_fmt[6], n_fmt[5], n_fmt[4]};
        n_out.byte_rate       = {n_fmt[11], n_fmt[10], n_fmt[9], n_fmt[8]};
        n_out.block_align     = {n_fmt[13], n_fmt[12]};
        n_out.bits_per_sample = {n_fmt[15], n_fmt[14]};
        n_out.extra_size      = (tag == FMT_PCM) ? 16'd0 : {n_fmt[17], n_fmt[16]};
        n_out.data_size       = (n_phase == PH_DATA || n_phase == PH_DONE) ? n_size : 32'd0;
    end

    // State and result update when a byte leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RIFF;
            r_bif       <= '0;
            r_id        <= '0;
            r_size      <= '0;
            r_left      <= '0;
            r_seen      <= 1'b0;
            r_off       <= '0;
            for (int k = 0; k < FMT_LEN; k++) r_fmt[k] <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_advance) begin
                r_phase <= n_phase;
                r_bif   <= n_bif;
                r_id    <= n_id;
                r_size  <= n_size;
                r_left  <= n_left;
                r_seen  <= n_seen;
                r_off   <= n_off;
                r_fmt   <= n_fmt;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (s1_advance) begin
            r_out <= n_out;
        end
    end

    // Result beat.
    assign o_out.valid           = r_out_valid;
    assign o_out.kind            = r_out.kind;
    assign o_out.data_byte       = r_out.data_byte;
    assign o_out.last_payload    = r_out.last_payload;
    assign o_out.format_class    = r_out.format_class;
    assign o_out.format_tag      = r_out.format_tag;
    assign o_out.channels        = r_out.channels;
    assign o_out.sample_rate     = r_out.sample_rate;
    assign o_out.byte_rate       = r_out.byte_rate;
    assign o_out.block_align     = r_out.block_align;
    assign o_out.bits_per_sample = r_out.bits_per_sample;
    assign o_out.extra_size      = r_out.extra_size;
    assign o_out.data_size       = r_out.data_size;

    // The last payload byte is always a payload result.
    `RWHP_ASSERT_NOW(a_last_is_payload, i_clk, i_rst_n, r_out_valid && r_out.last_payload, r_out.kind == KIND_PAYLOAD)
    // A payload result always reports a nonzero data size.
    `RWHP_ASSERT_NOW(a_payload_size, i_clk, i_rst_n, r_out_valid && r_out.kind == KIND_PAYLOAD, r_out.data_size != 32'd0)
    // After the last payload byte the parser sits in the done phase.
    `RWHP_ASSERT_NEXT(a_last_to_done, i_clk, i_rst_n, s1_advance && n_out.last_payload, r_phase == PH_DONE)
    // A byte held in the input register is not lost while the output stalls.
    `RWHP_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s1_advance, r_s1_valid)

endmodule
